// ===== hdl/shadr_pkg.sv =====
package shadr_pkg;

  // Instruction selector carried in the low nibble of the input tdata.
  typedef enum logic [3:0] {
    MODE_LOAD_REG   = 4'd0,
    MODE_ROTCL      = 4'd1,
    MODE_ROTCR      = 4'd2,
    MODE_ROTL       = 4'd3,
    MODE_ROTR       = 4'd4,
    MODE_DIV0S      = 4'd5,
    MODE_DIV0U      = 4'd6,
    MODE_DIV1       = 4'd7,
    MODE_MULL       = 4'd8,
    MODE_NEGC       = 4'd9,
    MODE_SWAPB      = 4'd10,
    MODE_SWAPW      = 4'd11,
    MODE_LOAD_FLAGS = 4'd12
  } mode_t;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REG_IDX_W  = 4;
  localparam int unsigned REG_COUNT  = 1 << REG_IDX_W;
  localparam int unsigned MODE_W     = 4;

  // Bit positions of the status bits in load_value for the flag load.
  localparam int unsigned LV_T_BIT = 0;
  localparam int unsigned LV_Q_BIT = 1;
  localparam int unsigned LV_M_BIT = 2;

  typedef struct packed {
    logic m;
    logic q;
    logic t;
  } flags_t;

endpackage

// ===== hdl/shadr_exec.sv =====
module shadr_exec (
  input  logic [shadr_pkg::MODE_W-1:0] mode,
  input  logic [shadr_pkg::DATA_W-1:0] vn,
  input  logic [shadr_pkg::DATA_W-1:0] vm,
  input  logic [shadr_pkg::DATA_W-1:0] load_value,
  input  logic [shadr_pkg::DATA_W-1:0] macl,
  input  shadr_pkg::flags_t            flags,
  output logic [shadr_pkg::DATA_W-1:0] rn_next,
  output logic [shadr_pkg::DATA_W-1:0] macl_next,
  output shadr_pkg::flags_t            flags_next
);

  logic [shadr_pkg::DATA_W-1:0] shifted;
  logic [shadr_pkg::DATA_W:0]   div_sub;
  logic [shadr_pkg::DATA_W:0]   div_add;
  logic                         div_same;
  logic                         div_carry;
  logic                         div_q;
  logic [shadr_pkg::DATA_W-1:0] mul_lo;

  // DIV1: shift in T, then subtract when Q equals M, otherwise add.
  assign shifted   = {vn[shadr_pkg::DATA_W-2:0], flags.t};
  assign div_sub   = {1'b0, shifted} - {1'b0, vm};
  assign div_add   = {1'b0, shifted} + {1'b0, vm};
  assign div_same  = (flags.q == flags.m);
  assign div_carry = div_same ? div_sub[shadr_pkg::DATA_W] : div_add[shadr_pkg::DATA_W];
  assign div_q     = vn[shadr_pkg::DATA_W-1] ^ div_carry ^ flags.m;

  assign mul_lo = vn * vm;

  always_comb begin
    rn_next    = vn;
    macl_next  = macl;
    flags_next = flags;
    case (mode)
      shadr_pkg::MODE_LOAD_REG: begin
        rn_next = load_value;
      end
      shadr_pkg::MODE_ROTCL: begin
        rn_next      = shifted;
        flags_next.t = vn[shadr_pkg::DATA_W-1];
      end
      shadr_pkg::MODE_ROTCR: begin
        rn_next      = {flags.t, vn[shadr_pkg::DATA_W-1:1]};
        flags_next.t = vn[0];
      end
      shadr_pkg::MODE_ROTL: begin
        rn_next      = {vn[shadr_pkg::DATA_W-2:0], vn[shadr_pkg::DATA_W-1]};
        flags_next.t = vn[shadr_pkg::DATA_W-1];
      end
      shadr_pkg::MODE_ROTR: begin
        rn_next      = {vn[0], vn[shadr_pkg::DATA_W-1:1]};
        flags_next.t = vn[0];
      end
      shadr_pkg::MODE_DIV0S: begin
        flags_next.q = vn[shadr_pkg::DATA_W-1];
        flags_next.m = vm[shadr_pkg::DATA_W-1];
        flags_next.t = vn[shadr_pkg::DATA_W-1] ^ vm[shadr_pkg::DATA_W-1];
      end
      shadr_pkg::MODE_DIV0U: begin
        flags_next = '0;
      end
      shadr_pkg::MODE_DIV1: begin
        rn_next      = div_same ? div_sub[shadr_pkg::DATA_W-1:0]
                                : div_add[shadr_pkg::DATA_W-1:0];
        flags_next.q = div_q;
        flags_next.t = (div_q == flags.m);
      end
      shadr_pkg::MODE_MULL: begin
        macl_next = mul_lo;
      end
      shadr_pkg::MODE_NEGC: begin
        rn_next      = '0 - vm - {{(shadr_pkg::DATA_W-1){1'b0}}, flags.t};
        flags_next.t = (vm != '0) || flags.t;
      end
      shadr_pkg::MODE_SWAPB: begin
        rn_next = {vm[31:16], vm[7:0], vm[15:8]};
      end
      shadr_pkg::MODE_SWAPW: begin
        rn_next = {vm[15:0], vm[31:16]};
      end
      shadr_pkg::MODE_LOAD_FLAGS: begin
        flags_next.t = load_value[shadr_pkg::LV_T_BIT];
        flags_next.q = load_value[shadr_pkg::LV_Q_BIT];
        flags_next.m = load_value[shadr_pkg::LV_M_BIT];
      end
      default: begin
        rn_next = vn;
      end
    endcase
  end

endmodule

// ===== hdl/sh_alu_divide_rotate_unit_top.sv =====
// SuperH-style ALU step unit: each input transaction is one instruction
// (register load, ROTCL/ROTCR/ROTL/ROTR, DIV0S/DIV0U/DIV1, MUL.L into MACL,
// NEGC, SWAP.B/SWAP.W, status load) executed against a 16 x 32-bit register
// file, MACL and the T/Q/M bits; each produces one output transaction with
// the new Rn, MACL and flags. Throughput is one instruction per clock while
// m_axis_tready does not stall the output: the register file is read into
// the input stage at the accepting edge, the instruction executes in one pass
// and commits to state as it moves into the output register. A result from the
// instruction committing at the same edge as an accept is forwarded to it,
// so dependent instructions run back to back. Modes 13 to 15 change nothing
// and report the current state. The register file reads as zero after
// reset without a clearing pass (per-entry valid bits).
module sh_alu_divide_rotate_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] mode, [7:4] reg_n, [11:8] reg_m, [43:12] load_value, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] rn_value, [63:32] macl_value, [64] t_flag, [65] q_flag,
  // [66] m_flag, [71:67] zero
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned DW = shadr_pkg::DATA_W;
  localparam int unsigned IW = shadr_pkg::REG_IDX_W;

  // input field unpack
  logic [shadr_pkg::MODE_W-1:0] in_mode;
  logic [IW-1:0]                in_rn;
  logic [IW-1:0]                in_rm;
  logic [DW-1:0]                in_lv;

  assign in_mode = s_axis_tdata[3:0];
  assign in_rn   = s_axis_tdata[7:4];
  assign in_rm   = s_axis_tdata[11:8];
  assign in_lv   = s_axis_tdata[43:12];

  logic in_fire;
  logic out_free;
  logic adv;     // execute stage commits and moves to the output register

  // execute stage
  logic                         s1_valid;
  logic [shadr_pkg::MODE_W-1:0] s1_mode;
  logic [IW-1:0]                s1_rn;
  logic [DW-1:0]                s1_lv;
  logic [DW-1:0]                rd_n;
  logic [DW-1:0]                rd_m;
  logic                         rd_n_vld;
  logic                         rd_m_vld;
  logic                         byp_n;
  logic                         byp_m;
  logic [DW-1:0]                byp_val;
  logic [DW-1:0]                vn;
  logic [DW-1:0]                vm;

  // architectural state
  logic [DW-1:0]                regs [shadr_pkg::REG_COUNT];
  logic [shadr_pkg::REG_COUNT-1:0] vld;
  logic [DW-1:0]                macl;
  shadr_pkg::flags_t            flags;

  // execute results
  logic [DW-1:0]                ex_rn;
  logic [DW-1:0]                ex_macl;
  shadr_pkg::flags_t            ex_flags;

  // output register
  logic                         out_valid;
  logic [DW-1:0]                out_rn;
  logic [DW-1:0]                out_macl;
  shadr_pkg::flags_t            out_flags;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign adv           = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;

  // operand select: forwarded value, else file entry (zero if never written)
  assign vn = byp_n ? byp_val : (rd_n_vld ? rd_n : '0);
  assign vm = byp_m ? byp_val : (rd_m_vld ? rd_m : '0);

  shadr_exec u_exec (
    .mode       (s1_mode),
    .vn         (vn),
    .vm         (vm),
    .load_value (s1_lv),
    .macl       (macl),
    .flags      (flags),
    .rn_next    (ex_rn),
    .macl_next  (ex_macl),
    .flags_next (ex_flags)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      vld       <= '0;
      macl      <= '0;
      flags     <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid  <= 1'b1;
        vld[s1_rn] <= 1'b1;
        macl       <= ex_macl;
        flags      <= ex_flags;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // register file; Rn is always rewritten (unchanged for non-writing modes)
  always_ff @(posedge clk) begin
    if (adv) begin
      regs[s1_rn] <= ex_rn;
    end
    if (in_fire) begin
      rd_n <= regs[in_rn];
      rd_m <= regs[in_rm];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode  <= in_mode;
      s1_rn    <= in_rn;
      s1_lv    <= in_lv;
      rd_n_vld <= vld[in_rn];
      rd_m_vld <= vld[in_rm];
      byp_n    <= adv && (s1_rn == in_rn);
      byp_m    <= adv && (s1_rn == in_rm);
      byp_val  <= ex_rn;
    end
    if (adv) begin
      out_rn    <= ex_rn;
      out_macl  <= ex_macl;
      out_flags <= ex_flags;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_flags.m, out_flags.q, out_flags.t, out_macl, out_rn};

`ifndef SYNTHESIS
  // forwarding is only ever armed by an instruction committing at the accept
  a_byp_source: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !adv) |=> !(byp_n || byp_m))
    else $error("operand forward without a committing instruction");

  // a commit always lands in the output register
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_axis_tvalid)
    else $error("committed transaction missing from output");

  // DIV0U clears all status bits
  a_div0u_clear: assert property (@(posedge clk) disable iff (rst)
    (adv && (s1_mode == shadr_pkg::MODE_DIV0U)) |=> (flags == '0))
    else $error("DIV0U left a status bit set");
`endif

endmodule
